FILE: design/pps_pkg.sv
package pps_pkg;

  localparam int MAX_JOBS_DEF = 16;

  // Input opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_LOAD_OK  = 3'd0;
  localparam logic [2:0] KIND_LOAD_REJ = 3'd1;
  localparam logic [2:0] KIND_IDLE     = 3'd2;
  localparam logic [2:0] KIND_RAN      = 3'd3;
  localparam logic [2:0] KIND_PREEMPT  = 3'd4;
  localparam logic [2:0] KIND_FINISHED = 3'd5;
  localparam logic [2:0] KIND_CLEARED  = 3'd6;

  // One job table entry as it is kept in the job memory.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } job_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SCAN,
    DP_LOAD,
    DP_CLEAR,
    DP_IDLE_TICK,
    DP_TAKE_OVER,
    DP_PREEMPT,
    DP_RUN,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic switch_job;
    logic running_none;
    logic scan_last;
    logic rem_last;
    logic out_free;
  } sts_t;

endpackage

FILE: design/pps_if.sv
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] arrival;
  logic [15:0] burst;
  logic [7:0]  priority_req;

  modport source (output valid, output opcode, output arrival, output burst,
                  output priority_req, input ready);
  modport sink (input valid, input opcode, input arrival, input burst,
                input priority_req, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [31:0] segment_start;
  logic [31:0] segment_end;
  logic [31:0] turnaround;
  logic [31:0] waiting;
  logic        last;

  modport source (output valid, output kind, output slot, output segment_start,
                  output segment_end, output turnaround, output waiting,
                  output last, input ready);
  modport sink (input valid, input kind, input slot, input segment_start,
                input segment_end, input turnaround, input waiting,
                input last, output ready);
endinterface

FILE: design/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pps_ctrl.sv
module pps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  input  logic [1:0]    opcode,
  output logic          ready,
  input  pps_pkg::sts_t sts,
  output pps_pkg::cmd_t ctl
);
  import pps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_IDLE_TICK,
    ST_PREEMPT,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl.op     = DP_NOP;
    ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (valid) begin
          ctl.op = DP_CAPTURE;
          priority if (opcode == OP_LOAD) begin
            state_next = ST_LOAD;
          end else if (opcode == OP_TICK) begin
            state_next = ST_SCAN;
          end else if (opcode == OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          ctl.op     = DP_LOAD;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sts.out_free) begin
          ctl.op     = DP_CLEAR;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ctl.op = DP_SCAN;
        if (sts.scan_last) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (!sts.found) begin
          state_next = ST_IDLE_TICK;
        end else if (sts.switch_job && !sts.running_none) begin
          state_next = ST_PREEMPT;
        end else begin
          if (sts.switch_job) begin
            ctl.op = DP_TAKE_OVER;
          end
          state_next = ST_RUN;
        end
      end
      ST_IDLE_TICK: begin
        if (sts.out_free) begin
          ctl.op     = DP_IDLE_TICK;
          state_next = ST_IDLE;
        end
      end
      ST_PREEMPT: begin
        if (sts.out_free) begin
          ctl.op     = DP_PREEMPT;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          ctl.op     = DP_RUN;
          state_next = sts.rem_last ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          ctl.op     = DP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The scan always runs through the whole table before a decision.
  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> $past(state) == ST_SCAN_LAST)
    else $error("decision reached without a completed scan");

  a_run_needs_pick: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> sts.found)
    else $error("run state entered with no job picked");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.op == DP_CAPTURE |-> state == ST_IDLE && valid)
    else $error("item captured outside idle");

endmodule

FILE: design/pps_dp.sv
module pps_dp #(
  parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pps_pkg::cmd_t ctl,
  output pps_pkg::sts_t sts,
  input  logic [15:0]   arrival,
  input  logic [15:0]   burst,
  input  logic [7:0]    priority_req,
  output logic          valid,
  input  logic          ready,
  output logic [2:0]    kind,
  output logic [3:0]    slot,
  output logic [31:0]   segment_start,
  output logic [31:0]   segment_end,
  output logic [31:0]   turnaround,
  output logic [31:0]   waiting,
  output logic          last
);
  import pps_pkg::*;

  localparam int SW = $clog2(MAX_JOBS);
  localparam int LW = $clog2(MAX_JOBS + 1);
  localparam logic [LW-1:0] NONE      = LW'(MAX_JOBS);
  localparam logic [SW-1:0] LAST_ADDR = SW'(MAX_JOBS - 1);

  // Captured load fields.
  logic [15:0] arr_cap;
  logic [15:0] bur_cap;
  logic [7:0]  pri_cap;

  logic [LW-1:0] jobs_loaded;
  logic [31:0]   current_time;
  logic [LW-1:0] running_slot;
  logic [31:0]   running_since;

  logic [SW-1:0] scan_addr;
  logic          rd_vld;
  logic [SW-1:0] rd_idx;
  logic          found;
  logic [SW-1:0] best_idx;
  job_t          best;
  logic [31:0]   turn;

  logic                 we;
  logic [SW-1:0]        waddr;
  job_t                 wdata;
  logic [$bits(job_t)-1:0] rdata;
  job_t                 rd_job;

  logic        cand;
  logic        better;
  logic        reject;
  logic [31:0] time_inc;
  logic [15:0] rem_next;
  logic [31:0] wait_val;

  logic        emit;
  logic [2:0]  e_kind;
  logic [3:0]  e_slot;
  logic [31:0] e_start;
  logic [31:0] e_end;
  logic [31:0] e_turn;
  logic [31:0] e_wait;
  logic        e_last;

  pps_ram #(
    .WIDTH($bits(job_t)),
    .DEPTH(MAX_JOBS)
  ) u_jobs (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(scan_addr),
    .rdata(rdata)
  );

  assign rd_job = job_t'(rdata);

  always_comb begin
    cand = rd_vld && (LW'(rd_idx) < jobs_loaded) && (rd_job.remaining != 16'd0) &&
           ({16'd0, rd_job.arrival} <= current_time);
    better = !found || (rd_job.prio < best.prio) ||
             ((rd_job.prio == best.prio) && (rd_job.arrival < best.arrival));
    reject   = (bur_cap == 16'd0) || (jobs_loaded == NONE);
    time_inc = (current_time == 32'hFFFF_FFFF) ? current_time : current_time + 32'd1;
    rem_next = best.remaining - 16'd1;
    wait_val = (turn >= {16'd0, best.burst}) ? turn - {16'd0, best.burst} : 32'd0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = jobs_loaded[SW-1:0];
    wdata = '{arrival: arr_cap, burst: bur_cap, remaining: bur_cap, prio: pri_cap};
    if (ctl.op == DP_LOAD && !reject) begin
      we = 1'b1;
    end else if (ctl.op == DP_RUN) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = '{arrival: best.arrival, burst: best.burst, remaining: rem_next,
                prio: best.prio};
    end
  end

  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_IDLE;
    e_slot  = 4'd0;
    e_start = 32'd0;
    e_end   = 32'd0;
    e_turn  = 32'd0;
    e_wait  = 32'd0;
    e_last  = 1'b1;
    unique case (ctl.op)
      DP_LOAD: begin
        emit   = 1'b1;
        e_kind = reject ? KIND_LOAD_REJ : KIND_LOAD_OK;
        e_slot = reject ? 4'd0 : 4'(jobs_loaded);
      end
      DP_CLEAR: begin
        emit   = 1'b1;
        e_kind = KIND_CLEARED;
      end
      DP_IDLE_TICK: begin
        emit   = 1'b1;
        e_kind = KIND_IDLE;
        e_end  = time_inc;
      end
      DP_PREEMPT: begin
        emit    = 1'b1;
        e_kind  = KIND_PREEMPT;
        e_slot  = 4'(running_slot);
        e_start = running_since;
        e_end   = current_time;
        e_last  = 1'b0;
      end
      DP_RUN: begin
        emit   = (rem_next != 16'd0);
        e_kind = KIND_RAN;
        e_slot = 4'(best_idx);
        e_end  = time_inc;
      end
      DP_FINISH: begin
        emit    = 1'b1;
        e_kind  = KIND_FINISHED;
        e_slot  = 4'(best_idx);
        e_start = running_since;
        e_end   = current_time;
        e_turn  = turn;
        e_wait  = wait_val;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      jobs_loaded   <= '0;
      current_time  <= 32'd0;
      running_slot  <= NONE;
      running_since <= 32'd0;
      rd_vld        <= 1'b0;
      found         <= 1'b0;
      scan_addr     <= '0;
    end else begin
      if (emit) begin
        valid <= 1'b1;
      end else if (ready) begin
        valid <= 1'b0;
      end
      rd_vld <= (ctl.op == DP_SCAN);
      if (cand && better) begin
        found <= 1'b1;
      end
      unique case (ctl.op)
        DP_CAPTURE: begin
          scan_addr <= '0;
          found     <= 1'b0;
        end
        DP_SCAN: begin
          scan_addr <= scan_addr + SW'(1);
        end
        DP_LOAD: begin
          if (!reject) begin
            jobs_loaded <= jobs_loaded + LW'(1);
          end
        end
        DP_CLEAR: begin
          jobs_loaded   <= '0;
          current_time  <= 32'd0;
          running_slot  <= NONE;
          running_since <= 32'd0;
        end
        DP_IDLE_TICK: begin
          current_time <= time_inc;
        end
        DP_TAKE_OVER, DP_PREEMPT: begin
          running_since <= current_time;
          running_slot  <= LW'(best_idx);
        end
        DP_RUN: begin
          current_time <= time_inc;
        end
        DP_FINISH: begin
          running_slot <= NONE;
        end
        default: begin
          running_slot <= running_slot;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == DP_CAPTURE) begin
      arr_cap <= arrival;
      bur_cap <= burst;
      pri_cap <= priority_req;
    end
    rd_idx <= scan_addr;
    if (cand && better) begin
      best_idx <= rd_idx;
      best     <= rd_job;
    end
    if (ctl.op == DP_RUN) begin
      turn <= time_inc - {16'd0, best.arrival};
    end
    if (emit) begin
      kind          <= e_kind;
      slot          <= e_slot;
      segment_start <= e_start;
      segment_end   <= e_end;
      turnaround    <= e_turn;
      waiting       <= e_wait;
      last          <= e_last;
    end
  end

  always_comb begin
    sts.found        = found;
    sts.switch_job   = (LW'(best_idx) != running_slot);
    sts.running_none = (running_slot == NONE);
    sts.scan_last    = (scan_addr == LAST_ADDR);
    sts.rem_last     = (best.remaining == 16'd1);
    sts.out_free     = !valid || ready;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!valid || ready))
    else $error("result register overwritten before it was taken");

  a_running_loaded: assert property (@(posedge clk) disable iff (rst)
    running_slot == NONE || running_slot < jobs_loaded)
    else $error("running slot points past the loaded jobs");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    jobs_loaded <= NONE)
    else $error("job count exceeds table size");

endmodule

FILE: design/preemptive_priority_scheduler_top.sv
// Load and clear: the item is captured on acceptance and the result is registered
// in the load or clear state once the output register is free.
// Tick: a full scan of all MAX_JOBS slots through the job memory read port, then
// decide and update, with an extra step for a preemption segment and another for
// a finish record.
// One item is processed at a time; a new item is taken as soon as the previous
// one has placed its final result in the output register. Synchronous reset
// empties the table, zeroes time and marks no job running; no clearing pass.
module preemptive_priority_scheduler_top #(
  parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
  input logic   clk,
  input logic   rst,
  pps_in_if.sink    cmd,
  pps_out_if.source res
);
  import pps_pkg::*;

  // The controller sequences each item; the datapath owns the job memory,
  // the time and running-job registers, the scan comparator and the output
  // register that decouples the result side from the command side.
  cmd_t ctl;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (cmd.valid),
    .opcode(cmd.opcode),
    .ready (cmd.ready),
    .sts   (sts),
    .ctl   (ctl)
  );

  // A tick reads each slot in order and keeps the best candidate so far, which
  // makes the lower slot win a full tie without extra logic.
  pps_dp #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .arrival      (cmd.arrival),
    .burst        (cmd.burst),
    .priority_req (cmd.priority_req),
    .valid        (res.valid),
    .ready        (res.ready),
    .kind         (res.kind),
    .slot         (res.slot),
    .segment_start(res.segment_start),
    .segment_end  (res.segment_end),
    .turnaround   (res.turnaround),
    .waiting      (res.waiting),
    .last         (res.last)
  );

endmodule

FILE: tb/sv/preemptive_priority_scheduler_top_tb.sv
module preemptive_priority_scheduler_top_tb;
  import pps_pkg::*;

  localparam int JOBS = MAX_JOBS_DEF;
  // The scheduler encodes "no job running" as one past the last slot.
  localparam int NO_JOB = JOBS;
  // The fourth opcode is not defined; the block drops it without a result.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int TARGET_ITEMS = 1800;
  // With sender gaps and receiver stalls a slow correct run stays far below
  // this limit, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 600000;

  // One result record, laid out in the same order as the result channel fields.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        last;
  } gantt_rec_t;

  // Keeps a private copy of the job table and the clock, predicts the records
  // each accepted item causes, and holds them until the block delivers them.
  class gantt_scoreboard;
    logic [15:0] arrival [JOBS];
    logic [15:0] burst [JOBS];
    logic [15:0] remaining [JOBS];
    logic [7:0]  prio [JOBS];
    bit          active [JOBS];
    int          loaded;
    logic [31:0] now;
    int          run_slot;
    logic [31:0] run_since;
    gantt_rec_t  due[$];
    int errors, records, commands;
    int loads_ok, loads_rejected, idle_ticks, runs, preemptions, finishes, clears;

    function new();
      clear_table();
    endfunction

    function void clear_table();
      foreach (active[i]) active[i] = 1'b0;
      loaded = 0;
      now = '0;
      run_slot = NO_JOB;
      run_since = '0;
    endfunction

    function void queue_record(logic [2:0] kind, int slot, logic [31:0] seg_start,
                               logic [31:0] seg_end, logic [31:0] turnaround,
                               logic [31:0] waiting, logic last);
      gantt_rec_t r;
      r.kind = kind;
      r.slot = slot[3:0];
      r.seg_start = seg_start;
      r.seg_end = seg_end;
      r.turnaround = turnaround;
      r.waiting = waiting;
      r.last = last;
      due.push_back(r);
    endfunction

    // Lowest priority number among arrived, unfinished jobs; equal priority
    // goes to the earlier arrival, and the strict compare keeps the lower slot.
    function int pick_winner();
      int best;
      best = NO_JOB;
      for (int i = 0; i < JOBS; i++) begin
        if (!active[i] || remaining[i] == 16'd0 || 32'(arrival[i]) > now) continue;
        if (best == NO_JOB || prio[i] < prio[best] ||
            (prio[i] == prio[best] && arrival[i] < arrival[best]))
          best = i;
      end
      return best;
    endfunction

    function void advance_clock();
      if (now != '1) now = now + 32'd1;
    endfunction

    function void note_command(logic [1:0] op, logic [15:0] arr, logic [15:0] bur,
                               logic [7:0] pri);
      int sel;
      logic [31:0] turn;
      if (op != OP_SPARE) commands++;
      case (op)
        OP_LOAD: begin
          if (bur == 16'd0 || loaded >= JOBS) begin
            queue_record(KIND_LOAD_REJ, 0, '0, '0, '0, '0, 1'b1);
            loads_rejected++;
          end else begin
            arrival[loaded] = arr;
            burst[loaded] = bur;
            remaining[loaded] = bur;
            prio[loaded] = pri;
            active[loaded] = 1'b1;
            queue_record(KIND_LOAD_OK, loaded, '0, '0, '0, '0, 1'b1);
            loaded++;
            loads_ok++;
          end
        end
        OP_TICK: begin
          sel = pick_winner();
          if (sel == NO_JOB) begin
            advance_clock();
            queue_record(KIND_IDLE, 0, '0, now, '0, '0, 1'b1);
            idle_ticks++;
          end else begin
            // A switch closes the Gantt segment of the job that was running.
            if (sel != run_slot) begin
              if (run_slot != NO_JOB) begin
                queue_record(KIND_PREEMPT, run_slot, run_since, now, '0, '0, 1'b0);
                preemptions++;
              end
              run_since = now;
              run_slot = sel;
            end
            remaining[sel] = remaining[sel] - 16'd1;
            advance_clock();
            if (remaining[sel] == 16'd0) begin
              turn = now - 32'(arrival[sel]);
              queue_record(KIND_FINISHED, sel, run_since, now, turn,
                           (turn >= 32'(burst[sel])) ? turn - 32'(burst[sel]) : '0, 1'b1);
              run_slot = NO_JOB;
              finishes++;
            end else begin
              queue_record(KIND_RAN, sel, '0, now, '0, '0, 1'b1);
              runs++;
            end
          end
        end
        OP_CLEAR: begin
          clear_table();
          queue_record(KIND_CLEARED, 0, '0, '0, '0, '0, 1'b1);
          clears++;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_record(gantt_rec_t got);
      gantt_rec_t want;
      records++;
      if (due.size() == 0) begin
        $error("result with nothing outstanding: kind %0d slot %0d", got.kind, got.slot);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("segment_start", want.seg_start, got.seg_start);
      compare_field("segment_end", want.seg_end, got.seg_end);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pps_in_if  cmd ();
  pps_out_if res ();

  preemptive_priority_scheduler_top dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  gantt_scoreboard sb;
  int cycles;
  int ready_mode;
  int burst_left;
  int items_sent;
  bit steady;

  // Both channels are observed at the clock edge, before any of this edge's
  // nonblocking updates land, so the sampled values are the ones the block saw.
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready)
      sb.note_command(cmd.opcode, cmd.arrival, cmd.burst, cmd.priority_req);
    if (!rst && res.valid && res.ready)
      sb.check_record({res.kind, res.slot, res.segment_start, res.segment_end,
                       res.turnaround, res.waiting, res.last});
  end

  // The receiver switches between stall patterns at random: always ready, coin
  // flips, a fixed duty cycle, or heavy back-pressure.
  // The same process owns the watchdog.
  initial begin
    res.ready = 1'b0;
    cycles = 0;
    ready_mode = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 300 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= 1'($urandom_range(0, 1));
        2: res.ready <= (cycles % 7) < 4;
        default: res.ready <= ($urandom_range(0, 4) == 0);
      endcase
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it. The sender runs
  // in bursts; at the end of a burst it drops valid for a random gap, short
  // or long enough to land while the block is busy or already idle. In a
  // steady phase the bursts follow one another with no gap at all.
  task automatic send_command(logic [1:0] op, logic [15:0] arr, logic [15:0] bur,
                              logic [7:0] pri);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        cmd.valid <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.opcode <= op;
    cmd.arrival <= arr;
    cmd.burst <= bur;
    cmd.priority_req <= pri;
    do @(posedge clk); while (!cmd.ready);
    if (op != OP_SPARE) items_sent++;
  endtask

  // Loads one job that will usually arrive soon after the current time, with
  // a short burst and a priority from a narrow range so that ties are common.
  // A few jobs get a burst of zero, a huge burst, or any priority at all.
  // The returned count is the run time the caller should budget in ticks.
  task automatic send_random_job(output int units);
    logic [15:0] arr;
    logic [15:0] bur;
    logic [7:0]  pri;
    if (sb.now < 32'd65000) begin
      if ($urandom_range(0, 4) == 0) arr = 16'($urandom_range(0, sb.now));
      else arr = 16'(sb.now) + 16'($urandom_range(0, 6));
    end else begin
      arr = 16'($urandom);
    end
    case ($urandom_range(0, 19))
      0: bur = 16'd0;
      1: bur = 16'($urandom_range(1, 65535));
      default: bur = 16'($urandom_range(1, 6));
    endcase
    pri = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    units = (bur > 16'd6) ? 8 : int'(bur);
    send_command(OP_LOAD, arr, bur, pri);
  endtask

  // A well-formed schedule: usually start from an empty table, load a set of
  // jobs (sometimes more than fit), then tick long enough for most of them
  // to finish. Late loads between ticks force preemptions mid-run.
  task automatic run_schedule_round();
    int n_jobs;
    int work;
    int units;
    steady = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 3) != 0)
      send_command(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
    n_jobs = $urandom_range(1, JOBS + 2);
    work = 0;
    repeat (n_jobs) begin
      send_random_job(units);
      work += units;
    end
    work += $urandom_range(0, 4);
    if (work > 80) work = 80;
    repeat (work) begin
      case ($urandom_range(0, 15))
        0: send_random_job(units);
        1: send_command(OP_SPARE, 16'($urandom), 16'($urandom), 8'($urandom));
        default: send_command(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    steady = 1'b0;
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.opcode <= OP_LOAD;
    cmd.arrival <= '0;
    cmd.burst <= '0;
    cmd.priority_req <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. An empty table gives an idle tick, a zero burst is
    // refused, and the undefined opcode is dropped.
    send_command(OP_TICK, 16'hffff, 16'hffff, 8'hff);
    send_command(OP_LOAD, 16'd0, 16'd0, 8'd0);
    send_command(OP_SPARE, 16'hffff, 16'hffff, 8'hff);
    // A background job with the longest burst and the worst priority, a job
    // that never arrives, and a short urgent job that runs to completion.
    send_command(OP_LOAD, 16'd0, 16'hffff, 8'hff);
    send_command(OP_LOAD, 16'hffff, 16'd1, 8'd0);
    send_command(OP_LOAD, 16'd0, 16'd2, 8'd5);
    repeat (3) send_command(OP_TICK, '0, '0, '0);
    // A late arrival preempts the background job and finishes in one tick.
    send_command(OP_LOAD, 16'd3, 16'd1, 8'd5);
    send_command(OP_TICK, '0, '0, '0);
    // Equal priority and arrival: the lower slot wins.
    send_command(OP_LOAD, 16'd0, 16'd3, 8'd7);
    send_command(OP_LOAD, 16'd0, 16'd2, 8'd7);
    send_command(OP_TICK, '0, '0, '0);
    // Equal priority: the earlier arrival wins over the lower slot, and the
    // switch closes the segment of a job that has not yet finished.
    send_command(OP_LOAD, 16'd2, 16'd4, 8'd6);
    send_command(OP_LOAD, 16'd1, 16'd4, 8'd6);
    repeat (3) send_command(OP_TICK, '0, '0, '0);
    send_command(OP_CLEAR, 16'h5a5a, 16'ha5a5, 8'h3c);
    send_command(OP_TICK, '0, '0, '0);

    // Random part: mostly whole schedules, with short runs of raw noise.
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        steady = 1'b0;
        repeat ($urandom_range(1, 5))
          send_command(2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        run_schedule_round();
      end
    end
    cmd.valid <= 1'b0;

    // Drain the remaining records, then give the block time to show any
    // stray result before the verdict.
    while (sb.due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d records from %0d items: %0d jobs stored, %0d loads refused, %0d clears.",
             sb.records, sb.commands, sb.loads_ok, sb.loads_rejected, sb.clears);
    $display("Ticks seen: %0d idle, %0d ran, %0d preemption segments, %0d jobs completed.",
             sb.idle_ticks, sb.runs, sb.preemptions, sb.finishes);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
